@@ hw/rtl/assert_macros.svh @@
// assertion macros used by the checker file ccmr_checker
// no dependencies; guarded against double inclusion
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled during reset
`define ASSERT_NXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

@@ hw/rtl/ccmr_pkg.sv @@
// types, codes and reset values for the cruise control mode regulator
// no dependencies; used by ccmr_step, the top level and the checker
package ccmr_pkg;

  localparam int unsigned PADDR_W = 5;

  typedef enum logic [1:0] {
    MODE_OFF   = 2'd0,
    MODE_SPEED = 2'd1,
    MODE_POWER = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    BLK_NONE  = 3'd0,
    BLK_BRAKE = 3'd1,
    BLK_FAULT = 3'd2,
    BLK_SPEED = 3'd3,
    BLK_PEDAL = 3'd4,
    BLK_LIMIT = 3'd5
  } blk_t;

  typedef enum logic [3:0] {
    EV_NONE         = 4'd0,
    EV_CANCEL_BRAKE = 4'd1,
    EV_CANCEL_WALK  = 4'd2,
    EV_CANCEL_PEDAL = 4'd3,
    EV_CANCEL_USER  = 4'd4,
    EV_RESUME_OK    = 4'd5,
    EV_RB_BRAKE     = 4'd6,
    EV_RB_SPEED     = 4'd7,
    EV_RB_PEDAL     = 4'd8,
    EV_RB_FAULT     = 4'd9,
    EV_RB_LIMIT     = 4'd10,
    EV_ENGAGE_SPEED = 4'd11,
    EV_ENGAGE_POWER = 4'd12
  } ev_t;

  // register word index (paddr[4:2])
  localparam logic [2:0] REG_MIN_ENGAGE = 3'd0;
  localparam logic [2:0] REG_MIN_PHOLD  = 3'd1;
  localparam logic [2:0] REG_GAIN       = 3'd2;
  localparam logic [2:0] REG_MAX_STEP   = 3'd3;
  localparam logic [2:0] REG_RESUME_WIN = 3'd4;

  localparam logic [9:0]  RST_MIN_ENGAGE = 10'd50;
  localparam logic [15:0] RST_MIN_PHOLD  = 16'd50;
  localparam logic [7:0]  RST_GAIN       = 8'd10;
  localparam logic [15:0] RST_MAX_STEP   = 16'd50;
  localparam logic [9:0]  RST_RESUME_WIN = 10'd20;

  typedef struct packed {
    logic [9:0]  min_engage_speed;
    logic [15:0] min_power_hold_watts;
    logic [7:0]  speed_gain;
    logic [15:0] max_step_watts;
    logic [9:0]  resume_speed_window;
  } ccmr_cfg_t;

  typedef struct packed {
    logic        brake;
    logic        press;
    logic        speed_select;
    logic        walk_active;
    logic        pedaling;
    logic [9:0]  speed;
    logic [15:0] req_power;
    logic [15:0] max_power;
    logic        fault;
    logic        limit_is_user;
    logic [9:0]  speed_cap;
    logic [15:0] fallback_power;
  } ccmr_item_t;

  typedef struct packed {
    mode_t       mode;
    logic        needs_ped;
    logic        res_avail;
    logic        res_needs_ped;
    mode_t       res_mode;
    blk_t        last_block;
    logic [9:0]  held_speed;
    logic [15:0] held_power;
    logic [15:0] cur_out;
  } ccmr_state_t;

  typedef struct packed {
    logic [15:0] power_out;
    mode_t       mode;
    logic        resume_ready;
    blk_t        block_reason;
    ev_t         event_code;
  } ccmr_result_t;

endpackage

@@ hw/rtl/ccmr_step.sv @@
// per-tick decision and power regulation of the cruise regulator
// depends on ccmr_pkg; purely combinational, state is held by the top level
module ccmr_step
  import ccmr_pkg::*;
(
  input  ccmr_cfg_t    cfg,
  input  ccmr_state_t  st,
  input  ccmr_item_t   it,
  output ccmr_state_t  st_next,
  output ccmr_result_t res
);

  ccmr_state_t mid;
  logic        do_reg;
  logic        drop;
  ev_t         ev;
  logic [9:0]  spd_diff;
  blk_t        blk;
  logic        saved_ok;

  logic signed [10:0] err;
  logic signed [19:0] prod;
  logic signed [19:0] cap_pos;
  logic signed [19:0] step;
  logic signed [20:0] sum;
  logic [15:0]        sat;
  logic [15:0]        spd_out;
  logic [15:0]        pwr_out;

  function automatic ev_t blk_event(input blk_t b);
    ev_t e;
    unique case (b)
      BLK_BRAKE: e = EV_RB_BRAKE;
      BLK_SPEED: e = EV_RB_SPEED;
      BLK_PEDAL: e = EV_RB_PEDAL;
      BLK_FAULT: e = EV_RB_FAULT;
      default:   e = EV_RB_LIMIT;
    endcase
    return e;
  endfunction

  assign spd_diff = (it.speed > st.held_speed) ? (it.speed - st.held_speed)
                                                : (st.held_speed - it.speed);
  assign saved_ok = (st.res_mode == MODE_SPEED) || (st.res_mode == MODE_POWER);

  // resume blocking reason, in priority order
  always_comb begin
    priority if (it.brake)                             blk = BLK_BRAKE;
    else if (it.fault)                                 blk = BLK_FAULT;
    else if (spd_diff > cfg.resume_speed_window)       blk = BLK_SPEED;
    else if (st.res_needs_ped && !it.pedaling)         blk = BLK_PEDAL;
    else if (!it.limit_is_user)                        blk = BLK_LIMIT;
    else                                               blk = BLK_NONE;
  end

  // mode transitions
  always_comb begin
    mid    = st;
    ev     = EV_NONE;
    do_reg = 1'b0;
    drop   = 1'b0;
    priority if (it.brake) begin
      if (st.mode != MODE_OFF) begin
        drop = 1'b1;
        ev   = EV_CANCEL_BRAKE;
      end else if (it.press && st.res_avail) begin
        mid.last_block = BLK_BRAKE;
        ev             = EV_RB_BRAKE;
      end
    end else if (it.walk_active) begin
      if (st.mode != MODE_OFF) begin
        drop = 1'b1;
        ev   = EV_CANCEL_WALK;
      end
    end else if (st.mode != MODE_OFF && st.needs_ped && !it.pedaling) begin
      drop = 1'b1;
      ev   = EV_CANCEL_PEDAL;
    end else if (it.press && st.mode != MODE_OFF) begin
      drop = 1'b1;
      ev   = EV_CANCEL_USER;
    end else if (it.press && st.res_avail) begin
      if (blk == BLK_NONE && saved_ok) begin
        mid.mode      = st.res_mode;
        mid.needs_ped = st.res_needs_ped;
        if (st.res_mode == MODE_SPEED && it.speed_cap != '0 &&
            st.held_speed > it.speed_cap) begin
          mid.held_speed = it.speed_cap;
        end
        mid.cur_out    = (st.held_power != '0) ? st.held_power : it.req_power;
        mid.res_avail  = 1'b0;
        mid.last_block = BLK_NONE;
        ev             = EV_RESUME_OK;
        do_reg         = 1'b1;
      end else begin
        // no reason but a bad saved mode is reported as a limit block
        mid.last_block = (blk == BLK_NONE) ? BLK_LIMIT : blk;
        ev             = blk_event((blk == BLK_NONE) ? BLK_LIMIT : blk);
      end
    end else if (it.press) begin
      if (it.speed >= cfg.min_engage_speed) begin
        if (it.speed_select || it.req_power < cfg.min_power_hold_watts) begin
          mid.mode = MODE_SPEED;
          ev       = EV_ENGAGE_SPEED;
        end else begin
          mid.mode = MODE_POWER;
          ev       = EV_ENGAGE_POWER;
        end
        mid.held_speed = (it.speed_cap != '0 && it.speed > it.speed_cap) ?
                         it.speed_cap : it.speed;
        mid.held_power = (it.req_power != '0) ? it.req_power : it.fallback_power;
        mid.cur_out    = (it.req_power != '0) ? it.req_power : it.fallback_power;
        mid.needs_ped  = it.pedaling;
        mid.res_avail  = 1'b0;
        mid.last_block = BLK_NONE;
        do_reg         = 1'b1;
      end
    end else begin
      do_reg = 1'b1;
    end

    // cancel saves the resume memory
    if (drop) begin
      mid.res_avail     = 1'b1;
      mid.res_needs_ped = st.needs_ped;
      mid.res_mode      = st.mode;
      mid.last_block    = BLK_NONE;
      mid.mode          = MODE_OFF;
      mid.cur_out       = '0;
      mid.needs_ped     = 1'b0;
    end
  end

  // speed-hold: clamped proportional step, then saturate and limit
  assign err     = $signed({1'b0, mid.held_speed}) - $signed({1'b0, it.speed});
  assign prod    = err * $signed({1'b0, cfg.speed_gain});
  assign cap_pos = $signed({4'b0, cfg.max_step_watts});

  always_comb begin
    priority if (prod > cap_pos)  step = cap_pos;
    else if (prod < -cap_pos)     step = -cap_pos;
    else                          step = prod;
  end

  assign sum = $signed({5'b0, mid.cur_out}) + $signed({step[19], step});

  always_comb begin
    priority if (sum < 0)                     sat = '0;
    else if (sum > $signed(21'd65535))        sat = 16'hFFFF;
    else                                      sat = sum[15:0];
  end

  assign spd_out = (it.max_power != '0 && sat > it.max_power) ? it.max_power : sat;
  assign pwr_out = (it.max_power != '0 && mid.held_power > it.max_power) ?
                   it.max_power : mid.held_power;

  always_comb begin
    st_next       = mid;
    res.power_out = it.req_power;
    if (do_reg) begin
      unique case (mid.mode)
        MODE_SPEED: begin
          st_next.cur_out = spd_out;
          res.power_out   = spd_out;
        end
        MODE_POWER: begin
          st_next.cur_out = pwr_out;
          res.power_out   = pwr_out;
        end
        default: res.power_out = it.req_power;
      endcase
    end
    res.mode         = st_next.mode;
    res.resume_ready = st_next.res_avail;
    res.block_reason = st_next.last_block;
    res.event_code   = ev;
  end

endmodule

@@ hw/rtl/cruise_control_mode_regulator_unit.sv @@
// top level of the cruise control mode regulator: config registers,
// input register, state and result register; uses ccmr_pkg and ccmr_step
//
// usage:
//   one control tick is one input beat on in_valid/in_stall carrying the
//   rider and drive flags, speed and the requested, limit and fallback powers.
//   each tick gives exactly one result beat on out_valid/out_stall with
//   power_out, mode, resume_ready, block_reason and event_code.
//   an accepted beat passes through the input register and then the result
//   register to the outputs. throughput: one beat per cycle while out_stall
//   is low; the tick logic sits between the input register and the result
//   register, and the mode state updates as a beat moves from one to the
//   other, so the following beat sees it at once. if the receiver stalls,
//   the result register holds its beat, the input register holds at most
//   one more beat, and in_stall is high while it holds one until out_stall drops.
//   configuration is an apb-style port, five 32-bit registers at byte
//   addresses 0..16; the user is to write them only while the block is idle,
//   the block itself does not enforce this. pready is always high and reads
//   return the register value. reset (rst, synchronous) clears mode state,
//   resume memory and both beat valid flags; config registers get their defaults.
module cruise_control_mode_regulator_unit
  import ccmr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               brake,
  input  logic               press,
  input  logic               speed_select,
  input  logic               walk_active,
  input  logic               pedaling,
  input  logic [9:0]         speed,
  input  logic [15:0]        req_power,
  input  logic [15:0]        max_power,
  input  logic               fault,
  input  logic               limit_is_user,
  input  logic [9:0]         speed_cap,
  input  logic [15:0]        fallback_power,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        power_out,
  output logic [1:0]         mode,
  output logic               resume_ready,
  output logic [2:0]         block_reason,
  output logic [3:0]         event_code
);

  ccmr_cfg_t    cfg;
  ccmr_state_t  st;
  ccmr_state_t  st_next;
  ccmr_item_t   s_item;
  logic         s_valid;
  ccmr_result_t o_res;
  ccmr_result_t res;
  logic         adv;
  logic         cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_engage_speed     <= RST_MIN_ENGAGE;
      cfg.min_power_hold_watts <= RST_MIN_PHOLD;
      cfg.speed_gain           <= RST_GAIN;
      cfg.max_step_watts       <= RST_MAX_STEP;
      cfg.resume_speed_window  <= RST_RESUME_WIN;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        REG_MIN_ENGAGE: cfg.min_engage_speed     <= pwdata[9:0];
        REG_MIN_PHOLD:  cfg.min_power_hold_watts <= pwdata[15:0];
        REG_GAIN:       cfg.speed_gain           <= pwdata[7:0];
        REG_MAX_STEP:   cfg.max_step_watts       <= pwdata[15:0];
        REG_RESUME_WIN: cfg.resume_speed_window  <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_MIN_ENGAGE: prdata = {22'd0, cfg.min_engage_speed};
      REG_MIN_PHOLD:  prdata = {16'd0, cfg.min_power_hold_watts};
      REG_GAIN:       prdata = {24'd0, cfg.speed_gain};
      REG_MAX_STEP:   prdata = {16'd0, cfg.max_step_watts};
      REG_RESUME_WIN: prdata = {22'd0, cfg.resume_speed_window};
      default:        prdata = '0;
    endcase
  end

  // beat moves from the input register to the result register
  assign adv      = s_valid && (!out_valid || !out_stall);
  assign in_stall = s_valid && !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (!in_stall) begin
      s_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s_item <= '{brake: brake, press: press, speed_select: speed_select,
                  walk_active: walk_active, pedaling: pedaling, speed: speed,
                  req_power: req_power, max_power: max_power,
                  fault: fault, limit_is_user: limit_is_user,
                  speed_cap: speed_cap, fallback_power: fallback_power};
    end
  end

  ccmr_step u_step (
    .cfg     (cfg),
    .st      (st),
    .it      (s_item),
    .st_next (st_next),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '{mode: MODE_OFF, needs_ped: 1'b0, res_avail: 1'b0,
              res_needs_ped: 1'b0, res_mode: MODE_OFF, last_block: BLK_NONE,
              held_speed: '0, held_power: '0, cur_out: '0};
    end else if (adv) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o_res <= res;
    end
  end

  assign power_out    = o_res.power_out;
  assign mode         = o_res.mode;
  assign resume_ready = o_res.resume_ready;
  assign block_reason = o_res.block_reason;
  assign event_code   = o_res.event_code;

endmodule

@@ hw/rtl/ccmr_checker.sv @@
// port-level checks for the cruise control mode regulator, bound to the top
// depends on ccmr_pkg and assert_macros.svh
`include "assert_macros.svh"

module ccmr_checker
  import ccmr_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] power_out,
  input logic [1:0]  mode,
  input logic        resume_ready,
  input logic [2:0]  block_reason,
  input logic [3:0]  event_code
);

  // a held result beat keeps its power_out and event_code
  `ASSERT_NXT(a_out_hold, clk, rst, out_valid && out_stall,
              out_valid && $stable(power_out) && $stable(event_code))

  // input side only backs up behind a stalled result beat
  `ASSERT_IMP(a_stall_cause, clk, rst, in_stall, out_valid && out_stall)

  // a cancel leaves cruise off with resume memory and no block
  `ASSERT_IMP(a_cancel, clk, rst,
              out_valid && (event_code == EV_CANCEL_BRAKE || event_code == EV_CANCEL_WALK ||
                            event_code == EV_CANCEL_PEDAL || event_code == EV_CANCEL_USER),
              mode == MODE_OFF && resume_ready && block_reason == BLK_NONE)

  // resume or engage clears the resume memory and turns cruise on
  `ASSERT_IMP(a_on, clk, rst,
              out_valid && (event_code == EV_RESUME_OK || event_code == EV_ENGAGE_SPEED ||
                            event_code == EV_ENGAGE_POWER),
              mode != MODE_OFF && !resume_ready && block_reason == BLK_NONE)

endmodule

bind cruise_control_mode_regulator_unit ccmr_checker u_ccmr_checker (.*);
